// ----- sv/ddvl_pkg.sv -----
// ddvl_pkg: shared constants and types for the differential drive velocity limiter
// no dependencies
package ddvl_pkg;
    localparam int SPEED_W      = 16;
    localparam int SUM_W        = 17;
    localparam int LIN_W        = 15;
    localparam int TURN_W       = 16;
    localparam int SCALE_BITS_D = 16;

    localparam logic CFG_LINEAR = 1'b0;
    localparam logic CFG_TURN   = 1'b1;

    typedef struct packed {
        logic lin_hit;
        logic trn_hit;
    } t_flags;
endpackage

// ----- sv/ddvl_div_cell.sv -----
// ddvl_div_cell: one restoring divide step for the linear and turn quotients
// depends on ddvl_pkg
module ddvl_div_cell #(
    parameter int SCALE_BITS = ddvl_pkg::SCALE_BITS_D
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_vld,
    input  logic [ddvl_pkg::SUM_W-1:0]             i_rem_a,
    input  logic [ddvl_pkg::SUM_W-1:0]             i_den_a,
    input  logic [SCALE_BITS-1:0]                  i_q_a,
    input  logic [ddvl_pkg::SUM_W-1:0]             i_rem_b,
    input  logic [ddvl_pkg::SUM_W-1:0]             i_den_b,
    input  logic [SCALE_BITS-1:0]                  i_q_b,
    input  logic signed [ddvl_pkg::SPEED_W-1:0]    i_left,
    input  logic signed [ddvl_pkg::SPEED_W-1:0]    i_right,
    input  ddvl_pkg::t_flags                       i_flags,
    output logic                                   o_vld,
    output logic [ddvl_pkg::SUM_W-1:0]             o_rem_a,
    output logic [ddvl_pkg::SUM_W-1:0]             o_den_a,
    output logic [SCALE_BITS-1:0]                  o_q_a,
    output logic [ddvl_pkg::SUM_W-1:0]             o_rem_b,
    output logic [ddvl_pkg::SUM_W-1:0]             o_den_b,
    output logic [SCALE_BITS-1:0]                  o_q_b,
    output logic signed [ddvl_pkg::SPEED_W-1:0]    o_left,
    output logic signed [ddvl_pkg::SPEED_W-1:0]    o_right,
    output ddvl_pkg::t_flags                       o_flags
);
    import ddvl_pkg::*;

    logic [SUM_W:0] w_sh_a, w_sh_b;
    logic           w_ge_a, w_ge_b;
    logic [SUM_W:0] w_df_a, w_df_b;

    // remainder stays below the divisor, so a shifted copy fits in SUM_W+1 bits
    assign w_sh_a = {i_rem_a, 1'b0};
    assign w_sh_b = {i_rem_b, 1'b0};
    assign w_ge_a = w_sh_a >= {1'b0, i_den_a};
    assign w_ge_b = w_sh_b >= {1'b0, i_den_b};
    assign w_df_a = w_sh_a - {1'b0, i_den_a};
    assign w_df_b = w_sh_b - {1'b0, i_den_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
        if (i_en) begin
            o_rem_a <= w_ge_a ? w_df_a[SUM_W-1:0] : w_sh_a[SUM_W-1:0];
            o_rem_b <= w_ge_b ? w_df_b[SUM_W-1:0] : w_sh_b[SUM_W-1:0];
            o_q_a   <= {i_q_a[SCALE_BITS-2:0], w_ge_a};
            o_q_b   <= {i_q_b[SCALE_BITS-2:0], w_ge_b};
            o_den_a <= i_den_a;
            o_den_b <= i_den_b;
            o_left  <= i_left;
            o_right <= i_right;
            o_flags <= i_flags;
        end
    end
endmodule

// ----- sv/diff_drive_velocity_limiter.sv -----
// diff_drive_velocity_limiter: top level, front stage, divider cell row, scaling stages
// depends on ddvl_pkg and ddvl_div_cell
//
//   channel  | handshake           | payload
//   input    | i_valid / o_ready   | i_left_speed, i_right_speed
//   output   | o_valid / i_ready   | o_left_out, o_right_out, o_*_hit, o_was_scaled
//   config   | i_cfg_we            | i_cfg_index, i_cfg_data
//
// one request per cycle while not stalled; stages in order: front stage, one divider
// cell per quotient bit, min stage, multiply stage, output register
// the pipeline advances only when its output register is free or being taken
// reset clears both limits (checks disabled) and all valid bits
module diff_drive_velocity_limiter #(
    parameter int SCALE_BITS = ddvl_pkg::SCALE_BITS_D
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [ddvl_pkg::SPEED_W-1:0] i_left_speed,
    input  logic signed [ddvl_pkg::SPEED_W-1:0] i_right_speed,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [ddvl_pkg::SPEED_W-1:0] o_left_out,
    output logic signed [ddvl_pkg::SPEED_W-1:0] o_right_out,
    output logic                                o_linear_hit,
    output logic                                o_turn_hit,
    output logic                                o_was_scaled,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [ddvl_pkg::TURN_W-1:0]         i_cfg_data
);
    import ddvl_pkg::*;

    localparam int N = SCALE_BITS;

    logic [LIN_W-1:0]  r_lin;
    logic [TURN_W-1:0] r_turn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin  <= '0;
            r_turn <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LINEAR: r_lin  <= i_cfg_data[LIN_W-1:0];
                CFG_TURN:   r_turn <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // whole pipeline stalls together
    logic w_adv;
    assign w_adv   = !o_valid || i_ready;
    assign o_ready = w_adv;

    // front stage
    logic signed [SUM_W-1:0] w_sum, w_dif;
    logic [SUM_W-1:0]        w_asum, w_adif, w_lin2;
    t_flags                  w_fl;
    assign w_sum  = SUM_W'(i_left_speed) + SUM_W'(i_right_speed);
    assign w_dif  = SUM_W'(i_right_speed) - SUM_W'(i_left_speed);
    assign w_asum = w_sum[SUM_W-1] ? SUM_W'(-w_sum) : w_sum;
    assign w_adif = w_dif[SUM_W-1] ? SUM_W'(-w_dif) : w_dif;
    assign w_lin2 = {1'b0, r_lin, 1'b0};
    assign w_fl.lin_hit = (r_lin != '0) && (w_asum > w_lin2);
    assign w_fl.trn_hit = (r_turn != '0) && (w_adif > SUM_W'(r_turn));

    logic                     r_f_vld;
    logic [SUM_W-1:0]         r_f_rem_a, r_f_den_a, r_f_rem_b, r_f_den_b;
    logic signed [SPEED_W-1:0] r_f_l, r_f_r;
    t_flags                   r_f_fl;

    // on a hit the numerator is below the divisor, so the quotient is all fraction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (w_adv) begin
            r_f_vld <= i_valid;
        end
        if (w_adv) begin
            r_f_rem_a <= w_fl.lin_hit ? w_lin2 : '0;
            r_f_den_a <= w_fl.lin_hit ? w_asum : SUM_W'(1);
            r_f_rem_b <= w_fl.trn_hit ? SUM_W'(r_turn) : '0;
            r_f_den_b <= w_fl.trn_hit ? w_adif : SUM_W'(1);
            r_f_l     <= i_left_speed;
            r_f_r     <= i_right_speed;
            r_f_fl    <= w_fl;
        end
    end

    // divider cell row
    logic                      c_vld   [N+1];
    logic [SUM_W-1:0]          c_rem_a [N+1];
    logic [SUM_W-1:0]          c_den_a [N+1];
    logic [N-1:0]              c_q_a   [N+1];
    logic [SUM_W-1:0]          c_rem_b [N+1];
    logic [SUM_W-1:0]          c_den_b [N+1];
    logic [N-1:0]              c_q_b   [N+1];
    logic signed [SPEED_W-1:0] c_l     [N+1];
    logic signed [SPEED_W-1:0] c_r     [N+1];
    t_flags                    c_fl    [N+1];

    assign c_vld[0]   = r_f_vld;
    assign c_rem_a[0] = r_f_rem_a;
    assign c_den_a[0] = r_f_den_a;
    assign c_q_a[0]   = '0;
    assign c_rem_b[0] = r_f_rem_b;
    assign c_den_b[0] = r_f_den_b;
    assign c_q_b[0]   = '0;
    assign c_l[0]     = r_f_l;
    assign c_r[0]     = r_f_r;
    assign c_fl[0]    = r_f_fl;

    // cells hold on stall through their enable
    for (genvar g = 0; g < N; g++) begin : g_cell
        ddvl_div_cell #(.SCALE_BITS(N)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_vld   (c_vld[g]),
            .i_rem_a (c_rem_a[g]), .i_den_a (c_den_a[g]), .i_q_a (c_q_a[g]),
            .i_rem_b (c_rem_b[g]), .i_den_b (c_den_b[g]), .i_q_b (c_q_b[g]),
            .i_left  (c_l[g]),     .i_right (c_r[g]),     .i_flags (c_fl[g]),
            .o_vld   (c_vld[g+1]),
            .o_rem_a (c_rem_a[g+1]), .o_den_a (c_den_a[g+1]), .o_q_a (c_q_a[g+1]),
            .o_rem_b (c_rem_b[g+1]), .o_den_b (c_den_b[g+1]), .o_q_b (c_q_b[g+1]),
            .o_left  (c_l[g+1]),     .o_right (c_r[g+1]),     .o_flags (c_fl[g+1])
        );
    end

    // min stage
    logic                      r_m_vld;
    logic [N:0]                r_m_scale;
    logic signed [SPEED_W-1:0] r_m_l, r_m_r;
    t_flags                    r_m_fl;
    logic [N:0]                w_sa, w_sb, w_mn;
    assign w_sa = c_fl[N].lin_hit ? {1'b0, c_q_a[N]} : {1'b1, {N{1'b0}}};
    assign w_sb = c_fl[N].trn_hit ? {1'b0, c_q_b[N]} : {1'b1, {N{1'b0}}};
    assign w_mn = (w_sa < w_sb) ? w_sa : w_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (w_adv) begin
            r_m_vld <= c_vld[N];
        end
        if (w_adv) begin
            r_m_scale <= w_mn;
            r_m_l     <= c_l[N];
            r_m_r     <= c_r[N];
            r_m_fl    <= c_fl[N];
        end
    end

    // multiply stage on magnitudes
    logic [SPEED_W:0]     w_ml, w_mr;
    logic [SPEED_W+N:0]   w_pl, w_pr;
    assign w_ml = r_m_l[SPEED_W-1] ? (SPEED_W+1)'(-$signed({r_m_l[SPEED_W-1], r_m_l}))
                                   : {1'b0, r_m_l};
    assign w_mr = r_m_r[SPEED_W-1] ? (SPEED_W+1)'(-$signed({r_m_r[SPEED_W-1], r_m_r}))
                                   : {1'b0, r_m_r};
    assign w_pl = (SPEED_W+N+1)'(w_ml) * (SPEED_W+N+1)'(r_m_scale);
    assign w_pr = (SPEED_W+N+1)'(w_mr) * (SPEED_W+N+1)'(r_m_scale);

    logic                      r_p_vld;
    logic [SPEED_W-1:0]        r_p_ml, r_p_mr;
    logic                      r_p_nl, r_p_nr;
    logic signed [SPEED_W-1:0] r_p_l, r_p_r;
    t_flags                    r_p_fl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (w_adv) begin
            r_p_vld <= r_m_vld;
        end
        if (w_adv) begin
            r_p_ml <= w_pl[N +: SPEED_W];
            r_p_mr <= w_pr[N +: SPEED_W];
            r_p_nl <= r_m_l[SPEED_W-1];
            r_p_nr <= r_m_r[SPEED_W-1];
            r_p_l  <= r_m_l;
            r_p_r  <= r_m_r;
            r_p_fl <= r_m_fl;
        end
    end

    // output register
    logic w_any;
    assign w_any = r_p_fl.lin_hit || r_p_fl.trn_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_adv) begin
            o_valid <= r_p_vld;
        end
        if (w_adv) begin
            o_left_out   <= !w_any ? r_p_l : (r_p_nl ? -$signed(r_p_ml) : $signed(r_p_ml));
            o_right_out  <= !w_any ? r_p_r : (r_p_nr ? -$signed(r_p_mr) : $signed(r_p_mr));
            o_linear_hit <= r_p_fl.lin_hit;
            o_turn_hit   <= r_p_fl.trn_hit;
            o_was_scaled <= w_any;
        end
    end
endmodule
